// ===== rtl/h2r_pkg.sv =====
// Shared types and constants of the HSV to RGB converter.
package h2r_pkg;

	// Input item: one HSV color
	typedef struct packed {
		logic [8:0] hue;
		logic [7:0] saturation;
		logic [7:0] brightness;
	} hsv_t;

	// Result item: one RGB color
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	// 60-degree hue sectors
	typedef enum logic [2:0] {
		SEC_R_TO_Y = 3'd0,
		SEC_Y_TO_G = 3'd1,
		SEC_G_TO_C = 3'd2,
		SEC_C_TO_B = 3'd3,
		SEC_B_TO_M = 3'd4,
		SEC_M_TO_R = 3'd5
	} sector_t;

	// Classified item handed from front to back through the queue
	typedef struct packed {
		sector_t    sector;
		logic [5:0] hue_dist;    // distance from the nearest primary, 0..60
		logic [7:0] chroma;      // round(S*V/255)
		logic [7:0] brightness;  // V
	} mid_t;

	localparam logic [8:0] HUE_MAX = 9'd360;
	localparam logic [8:0] DEG_60  = 9'd60;
	localparam logic [8:0] DEG_120 = 9'd120;
	localparam logic [8:0] DEG_180 = 9'd180;
	localparam logic [8:0] DEG_240 = 9'd240;
	localparam logic [8:0] DEG_300 = 9'd300;

	// floor(n/255) = (n * 0x8081) >> 23 for any 16-bit n
	localparam logic [15:0] RECIP_255 = 16'h8081;
	localparam int          SHIFT_255 = 23;
	// floor(n/15) = (n * 0x8889) >> 19 for any 16-bit n
	localparam logic [15:0] RECIP_15  = 16'h8889;
	localparam int          SHIFT_15  = 19;

	// rounding biases
	localparam logic [15:0] BIAS_255 = 16'd127;
	localparam logic [13:0] BIAS_60  = 14'd30;

	localparam int QUEUE_DEPTH = 4;

endpackage

// ===== rtl/h2r_front.sv =====
// Front part: accepts HSV items, finds sector and hue distance, computes chroma.
module h2r_front #(
	parameter int Depth = h2r_pkg::QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       hsv_valid,
	output logic                       hsv_stall,
	input  h2r_pkg::hsv_t              hsv,
	input  logic [$clog2(Depth+1)-1:0] q_count,
	output logic                       push,
	output h2r_pkg::mid_t              mid
);

	localparam int CntW = $clog2(Depth + 1);

	logic             accept;
	logic [8:0]       hue_c;
	logic [8:0]       r120;
	logic [5:0]       hue_dist;
	h2r_pkg::sector_t sector;

	logic             valid_s1;
	logic [15:0]      prod_s1;
	logic [7:0]       bri_s1;
	logic [5:0]       hue_dist_s1;
	h2r_pkg::sector_t sector_s1;

	logic             valid_s2;
	logic [7:0]       chroma_s2;
	logic [7:0]       bri_s2;
	logic [5:0]       hue_dist_s2;
	h2r_pkg::sector_t sector_s2;

	logic [15:0]      num;
	logic [31:0]      quot;
	logic [CntW:0]    used;

	// Credit check: queue entries plus items still in the front pipeline
	assign used      = {1'b0, q_count} + (CntW+1)'(valid_s1) + (CntW+1)'(valid_s2);
	assign hsv_stall = (used >= (CntW+1)'(Depth));
	assign accept    = hsv_valid && !hsv_stall;

	// Hue clamp, sector and distance to the nearest primary
	always_comb begin
		hue_c = (hsv.hue > h2r_pkg::HUE_MAX) ? h2r_pkg::HUE_MAX : hsv.hue;
		if (hue_c < h2r_pkg::DEG_60)
			sector = h2r_pkg::SEC_R_TO_Y;
		else if (hue_c < h2r_pkg::DEG_120)
			sector = h2r_pkg::SEC_Y_TO_G;
		else if (hue_c < h2r_pkg::DEG_180)
			sector = h2r_pkg::SEC_G_TO_C;
		else if (hue_c < h2r_pkg::DEG_240)
			sector = h2r_pkg::SEC_C_TO_B;
		else if (hue_c < h2r_pkg::DEG_300)
			sector = h2r_pkg::SEC_B_TO_M;
		else
			sector = h2r_pkg::SEC_M_TO_R;

		if (hue_c >= h2r_pkg::DEG_240)
			r120 = hue_c - h2r_pkg::DEG_240;
		else if (hue_c >= h2r_pkg::DEG_120)
			r120 = hue_c - h2r_pkg::DEG_120;
		else
			r120 = hue_c;

		// hue of 360 leaves r120 = 120, so the distance is zero
		if (r120 < h2r_pkg::DEG_60)
			hue_dist = r120[5:0];
		else
			hue_dist = 6'(h2r_pkg::DEG_120 - r120);
	end

	// Chroma: round(p/255) = floor((p + 127)/255)
	assign num  = prod_s1 + h2r_pkg::BIAS_255;
	assign quot = num * h2r_pkg::RECIP_255;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	// Payload stages
	always_ff @(posedge clk) begin
		prod_s1     <= hsv.saturation * hsv.brightness;
		bri_s1      <= hsv.brightness;
		hue_dist_s1 <= hue_dist;
		sector_s1   <= sector;

		chroma_s2   <= quot[h2r_pkg::SHIFT_255 +: 8];
		bri_s2      <= bri_s1;
		hue_dist_s2 <= hue_dist_s1;
		sector_s2   <= sector_s1;
	end

	assign push           = valid_s2;
	assign mid.sector     = sector_s2;
	assign mid.hue_dist   = hue_dist_s2;
	assign mid.chroma     = chroma_s2;
	assign mid.brightness = bri_s2;

endmodule

// ===== rtl/h2r_queue.sv =====
// Short queue between the front and back parts.
module h2r_queue #(
	parameter int Depth = h2r_pkg::QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  h2r_pkg::mid_t              wr_data,
	input  logic                       pop,
	output h2r_pkg::mid_t              rd_data,
	output logic                       empty,
	output logic [$clog2(Depth+1)-1:0] count
);

	localparam int PtrW = $clog2(Depth);
	localparam int CntW = $clog2(Depth + 1);

	h2r_pkg::mid_t   mem [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	// Storage
	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= wr_data;
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	assign rd_data = mem[rd_ptr_q];
	assign empty   = (count_q == '0);
	assign count   = count_q;

endmodule

// ===== rtl/h2r_back.sv =====
// Back part: computes the secondary component and assembles the RGB item.
module h2r_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  h2r_pkg::mid_t q_data,
	output logic          pop,
	output logic          rgb_valid,
	input  logic          rgb_stall,
	output h2r_pkg::rgb_t rgb
);

	logic             en;

	logic             valid_s1;
	logic [13:0]      cd_s1;
	logic [7:0]       c_s1;
	logic [7:0]       m_s1;
	h2r_pkg::sector_t sector_s1;

	logic             valid_s2;
	logic [7:0]       x_s2;
	logic [7:0]       c_s2;
	logic [7:0]       m_s2;
	h2r_pkg::sector_t sector_s2;

	logic             rgb_valid_q;
	h2r_pkg::rgb_t    rgb_q;

	logic [13:0]      cd_b;
	logic [11:0]      quarter;
	logic [27:0]      xprod;
	logic [7:0]       rs, gs, bs;

	// Whole back pipeline moves unless a result is held at the output
	assign en  = !(rgb_valid_q && rgb_stall);
	assign pop = en && !q_empty;

	// X = floor((C*d + 30)/60) = floor(((C*d + 30) >> 2)/15)
	assign cd_b    = cd_s1 + h2r_pkg::BIAS_60;
	assign quarter = cd_b[13:2];
	assign xprod   = quarter * h2r_pkg::RECIP_15;

	// Sector routing of C and X
	always_comb begin
		case (sector_s2)
			h2r_pkg::SEC_R_TO_Y: begin rs = c_s2; gs = x_s2; bs = '0;   end
			h2r_pkg::SEC_Y_TO_G: begin rs = x_s2; gs = c_s2; bs = '0;   end
			h2r_pkg::SEC_G_TO_C: begin rs = '0;   gs = c_s2; bs = x_s2; end
			h2r_pkg::SEC_C_TO_B: begin rs = '0;   gs = x_s2; bs = c_s2; end
			h2r_pkg::SEC_B_TO_M: begin rs = x_s2; gs = '0;   bs = c_s2; end
			default:             begin rs = c_s2; gs = '0;   bs = x_s2; end
		endcase
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			rgb_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= pop;
			valid_s2    <= valid_s1;
			rgb_valid_q <= valid_s2;
		end
	end

	// Payload stages
	always_ff @(posedge clk) begin
		if (en) begin
			cd_s1     <= q_data.chroma * q_data.hue_dist;
			c_s1      <= q_data.chroma;
			m_s1      <= q_data.brightness - q_data.chroma;
			sector_s1 <= q_data.sector;

			x_s2      <= xprod[h2r_pkg::SHIFT_15 +: 8];
			c_s2      <= c_s1;
			m_s2      <= m_s1;
			sector_s2 <= sector_s1;

			rgb_q.red   <= rs + m_s2;
			rgb_q.green <= gs + m_s2;
			rgb_q.blue  <= bs + m_s2;
		end
	end

	assign rgb_valid = rgb_valid_q;
	assign rgb       = rgb_q;

endmodule

// ===== rtl/hsv_to_rgb_converter.sv =====
// HSV to RGB converter: one RGB item out for every HSV item in.
// Path: an accepted item passes the front stages s1 and s2, the queue, and the back
// stages s1, s2 and the output register before it shows on rgb; the back stalls with the output.
// Throughput: one item per clock; hsv_stall rises only when the four-entry
// queue plus the two front stages hold four items.
// Reset clears all valid bits, the queue pointers and the queue fill level; nothing else needs it.
module hsv_to_rgb_converter #(
	parameter int Depth = h2r_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          hsv_valid,
	output logic          hsv_stall,
	input  h2r_pkg::hsv_t hsv,
	output logic          rgb_valid,
	input  logic          rgb_stall,
	output h2r_pkg::rgb_t rgb
);

	localparam int CntW = $clog2(Depth + 1);

	logic            push;
	logic            pop;
	logic            q_empty;
	logic [CntW-1:0] q_count;
	h2r_pkg::mid_t   mid_in;
	h2r_pkg::mid_t   mid_out;

	// Accept and classify
	h2r_front #(.Depth(Depth)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.hsv_valid (hsv_valid),
		.hsv_stall (hsv_stall),
		.hsv       (hsv),
		.q_count   (q_count),
		.push      (push),
		.mid       (mid_in)
	);

	// Decoupling queue
	h2r_queue #(.Depth(Depth)) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (mid_in),
		.pop     (pop),
		.rd_data (mid_out),
		.empty   (q_empty),
		.count   (q_count)
	);

	// Compute and deliver
	h2r_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (mid_out),
		.pop       (pop),
		.rgb_valid (rgb_valid),
		.rgb_stall (rgb_stall),
		.rgb       (rgb)
	);

endmodule

// ===== rtl/h2r_checker.sv =====
// Port-level checker for the HSV to RGB converter, bound to the top level.
module h2r_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          hsv_valid,
	input logic          hsv_stall,
	input h2r_pkg::hsv_t hsv,
	input logic          rgb_valid,
	input logic          rgb_stall,
	input h2r_pkg::rgb_t rgb
);

	// A held result stays valid and unchanged
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rgb_valid && rgb_stall |=> rgb_valid && $stable(rgb))
		else $error("rgb result changed while stalled");

	// Input stall only rises after an item was taken
	a_stall_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(hsv_stall) |-> $past(hsv_valid && !hsv_stall))
		else $error("hsv_stall rose without an accepted item");

	// A free output drains the queue, so the input stall lasts one cycle
	a_stall_clear: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_stall && !rgb_stall |=> !hsv_stall)
		else $error("hsv_stall held although the output was free");

endmodule

bind hsv_to_rgb_converter h2r_checker u_h2r_checker (.*);
